/* design/mbft_pkg.sv */
// Shared constants, types and the divider step function for the metaball field block.
`default_nettype none
package mbft_pkg;
    localparam int FRAC_BITS  = 4;
    localparam int PX_W       = 6;
    localparam int PY_W       = 5;
    localparam int CX_W       = 10;
    localparam int CY_W       = 9;
    localparam int WGT_W      = 8;
    localparam int BLOB_W     = 27;
    localparam int SUM_W      = 17;
    localparam int SQ_W       = 2 * CX_W + 1;
    localparam int D2_W       = 13;
    localparam int NUM_W      = 16;
    localparam int REM_W      = D2_W + 1;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = NUM_W / DIV_STEPS;
    localparam int MAX_BLOBS  = 5;
    localparam int IDX_W      = 3;
    localparam int DIST_LAT   = 3;

    localparam logic [IDX_W-1:0] REG_CORE = 3'd5;
    localparam logic [IDX_W-1:0] REG_GLOW = 3'd6;

    localparam logic [SUM_W-1:0] SUM_MAX        = 17'h1FFFF;
    localparam logic [SUM_W-1:0] CORE_TH_RESET  = 17'd1400;
    localparam logic [SUM_W-1:0] GLOW_TH_RESET  = 17'd900;
    localparam logic [15:0]      COLOUR_CORE    = 16'hF9E0;
    localparam logic [15:0]      COLOUR_GLOW    = 16'h7940;
    localparam logic [15:0]      COLOUR_BACK    = 16'h0004;

    localparam logic [BLOB_W-1:0] BLOB_RESET [MAX_BLOBS] = '{
        27'd47448576, 27'd31719936, 27'd57934336, 27'd23855616, 27'd39584256
    };

    typedef enum logic [1:0] {
        LVL_BACK = 2'd0,
        LVL_GLOW = 2'd1,
        LVL_CORE = 2'd2
    } t_level;

    // Partial remainder plus a shift register: dividend bits leave at the top,
    // quotient bits enter at the bottom.
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [NUM_W-1:0] num;
    } t_div_state;

    // Several restoring-division steps.
    function automatic t_div_state div_steps(input t_div_state s,
                                             input logic [D2_W-1:0] den);
        t_div_state       r;
        logic [REM_W-1:0] trial;
        r = s;
        for (int k = 0; k < DIV_STEPS; k++) begin
            trial = {r.rem[REM_W-2:0], r.num[NUM_W-1]};
            r.num = {r.num[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, den}) begin
                r.rem    = trial - {1'b0, den};
                r.num[0] = 1'b1;
            end else begin
                r.rem = trial;
            end
        end
        return r;
    endfunction
endpackage
`default_nettype wire

/* design/metaball_field_threshold.sv */
// Top level: blob registers, per-blob lanes, field sum and threshold stage.
// Register path from input transaction to result: distance lane, divider stages, then sum/compare registers.
// Throughput: one pixel per clock; the whole pipeline stalls only when the result is not taken.
// Each blob has its own distance lane and pipelined divider, 4 quotient bits per stage.
// Reset (synchronous, active low) clears valid bits and loads default blobs and thresholds.
`default_nettype none
module metaball_field_threshold
    import mbft_pkg::*;
#(
    parameter int BLOB_COUNT = MAX_BLOBS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [15:0]       s_axis_tdata,   // pixel_x[5:0], pixel_y[10:6], zero pad
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic      [39:0]       m_axis_tdata,   // level[1:0], colour[17:2], field_sum[34:18]
    input  wire logic              i_cfg_we,
    input  wire logic [IDX_W-1:0]  i_cfg_idx,
    input  wire logic [BLOB_W-1:0] i_cfg_data
);
    localparam int LAT   = DIST_LAT + DIV_STAGES + 2;
    localparam int ACC_W = NUM_W + $clog2(BLOB_COUNT + 1);

    logic [BLOB_W-1:0] r_blob [MAX_BLOBS];
    logic [SUM_W-1:0]  r_core_th, r_glow_th;
    logic [LAT-1:0]    r_vld;
    logic              w_en;
    logic [NUM_W-1:0]  w_quot [BLOB_COUNT];
    logic [ACC_W-1:0]  w_acc, r_acc;
    logic [SUM_W-1:0]  w_sum, r_sum;
    t_level            r_level;
    logic [15:0]       r_colour;

    assign w_en          = ~r_vld[LAT-1] | m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[LAT-1];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_BLOBS; i++) r_blob[i] <= BLOB_RESET[i];
            r_core_th <= CORE_TH_RESET;
            r_glow_th <= GLOW_TH_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx < IDX_W'(MAX_BLOBS))
                r_blob[i_cfg_idx] <= i_cfg_data;
            else if (i_cfg_idx == REG_CORE)
                r_core_th <= i_cfg_data[SUM_W-1:0];
            else if (i_cfg_idx == REG_GLOW)
                r_glow_th <= i_cfg_data[SUM_W-1:0];
        end
    end

    // Valid bits travel alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    // One lane per blob
    for (genvar b = 0; b < BLOB_COUNT; b++) begin : g_lane
        logic [D2_W-1:0]  w_d2;
        logic [NUM_W-1:0] w_num;

        mbft_dist u_dist (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_px   (s_axis_tdata[PX_W-1:0]),
            .i_py   (s_axis_tdata[PX_W+PY_W-1:PX_W]),
            .i_blob (r_blob[b]),
            .o_d2   (w_d2),
            .o_num  (w_num)
        );

        mbft_div u_div (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_num  (w_num),
            .i_den  (w_d2),
            .o_quot (w_quot[b])
        );
    end

    // Sum of blob terms
    always_comb begin
        w_acc = '0;
        for (int i = 0; i < BLOB_COUNT; i++) w_acc = w_acc + ACC_W'(w_quot[i]);
    end

    // Saturation: terms are non-negative, so clamping the total matches per-step clamping
    assign w_sum = (r_acc > ACC_W'(SUM_MAX)) ? SUM_MAX : r_acc[SUM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_acc <= w_acc;
            r_sum <= w_sum;
            if (w_sum > r_core_th) begin
                r_level  <= LVL_CORE;
                r_colour <= COLOUR_CORE;
            end else if (w_sum > r_glow_th) begin
                r_level  <= LVL_GLOW;
                r_colour <= COLOUR_GLOW;
            end else begin
                r_level  <= LVL_BACK;
                r_colour <= COLOUR_BACK;
            end
        end
    end

    assign m_axis_tdata = {5'd0, r_sum, r_colour, r_level};
endmodule
`default_nettype wire

/* design/mbft_dist.sv */
// Per-blob distance lane: offsets, squares, then scaled squared distance plus one.
`default_nettype none
module mbft_dist
    import mbft_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [PX_W-1:0]   i_px,
    input  wire logic [PY_W-1:0]   i_py,
    input  wire logic [BLOB_W-1:0] i_blob,
    output logic      [D2_W-1:0]   o_d2,
    output logic      [NUM_W-1:0]  o_num
);
    logic [CX_W-1:0]    w_cx, w_pxs;
    logic [CY_W-1:0]    w_cy, w_pys;
    logic [WGT_W-1:0]   w_wgt;
    logic [CX_W-1:0]    r_dx;
    logic [CY_W-1:0]    r_dy;
    logic [WGT_W-1:0]   r_wgt1, r_wgt2, r_wgt3;
    logic [2*CX_W-1:0]  r_sqx;
    logic [2*CY_W-1:0]  r_sqy;
    logic [SQ_W-1:0]    w_sq;
    logic [D2_W-1:0]    r_d2;

    assign w_cx  = i_blob[CX_W-1:0];
    assign w_cy  = i_blob[CX_W+CY_W-1:CX_W];
    assign w_wgt = i_blob[BLOB_W-1:CX_W+CY_W];
    assign w_pxs = {i_px, {FRAC_BITS{1'b0}}};
    assign w_pys = {i_py, {FRAC_BITS{1'b0}}};
    assign w_sq  = {1'b0, r_sqx} + {{(SQ_W-2*CY_W){1'b0}}, r_sqy};

    // Stage 1: absolute offsets; stage 2: squares; stage 3: d2
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx   <= (w_pxs >= w_cx) ? (w_pxs - w_cx) : (w_cx - w_pxs);
            r_dy   <= (w_pys >= w_cy) ? (w_pys - w_cy) : (w_cy - w_pys);
            r_wgt1 <= w_wgt;
            r_sqx  <= r_dx * r_dx;
            r_sqy  <= r_dy * r_dy;
            r_wgt2 <= r_wgt1;
            r_d2   <= w_sq[2*FRAC_BITS+D2_W-1:2*FRAC_BITS] + 1'b1;
            r_wgt3 <= r_wgt2;
        end
    end

    assign o_d2  = r_d2;
    assign o_num = {r_wgt3, 8'd0};
endmodule
`default_nettype wire

/* design/mbft_div.sv */
// Pipelined restoring divider, a few quotient bits per stage.
`default_nettype none
module mbft_div
    import mbft_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [D2_W-1:0]  i_den,
    output logic      [NUM_W-1:0] o_quot
);
    t_div_state      r_st  [DIV_STAGES];
    logic [D2_W-1:0] r_den [DIV_STAGES-1];
    t_div_state      w_in;

    assign w_in = '{rem: '0, num: i_num};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0]  <= div_steps(w_in, i_den);
            r_den[0] <= i_den;
        end
    end

    for (genvar g = 1; g < DIV_STAGES; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[g] <= div_steps(r_st[g-1], r_den[g-1]);
            end
        end

        // Divisor only travels as far as the last stage that still needs it
        if (g < DIV_STAGES - 1) begin : g_den
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[g] <= r_den[g-1];
                end
            end
        end
    end

    assign o_quot = r_st[DIV_STAGES-1].num;
endmodule
`default_nettype wire

/* sim/metaball_field_threshold_checker.sv */
// Checker for the metaball field block: mirrors the registers, predicts each pixel, compares.
`timescale 1ns / 1ps
`default_nettype none
module metaball_field_threshold_checker
    import mbft_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_ready,
    input  wire logic [15:0]       i_in_data,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_ready,
    input  wire logic [39:0]       i_out_data,
    input  wire logic              i_cfg_we,
    input  wire logic [IDX_W-1:0]  i_cfg_idx,
    input  wire logic [BLOB_W-1:0] i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_pixel_count
);
    typedef struct packed {
        t_level            level;
        logic [15:0]       colour;
        logic [SUM_W-1:0]  field_sum;
    } t_shade;

    logic [BLOB_W-1:0] blob_mirror [MAX_BLOBS];
    logic [SUM_W-1:0]  core_mirror, glow_mirror;
    t_shade            shade_queue [$];

    // Field strength of one blob at an integer pixel
    function automatic longint unsigned blob_strength(logic [BLOB_W-1:0] blob,
                                                      logic [PX_W-1:0] px,
                                                      logic [PY_W-1:0] py);
        longint signed   dx, dy;
        longint unsigned dist2;
        dx = longint'(px) * 16 - longint'(blob[9:0]);
        dy = longint'(py) * 16 - longint'(blob[18:10]);
        dist2 = ((dx * dx + dy * dy) >> 8) + 1;
        return (longint'(blob[26:19]) * 256) / dist2;
    endfunction

    function automatic t_shade shade_pixel(logic [PX_W-1:0] px, logic [PY_W-1:0] py);
        longint unsigned acc;
        t_shade          s;
        acc = 0;
        for (int b = 0; b < MAX_BLOBS; b++) begin
            acc += blob_strength(blob_mirror[b], px, py);
            if (acc > SUM_MAX) acc = SUM_MAX;
        end
        s.field_sum = acc[SUM_W-1:0];
        if (s.field_sum > core_mirror) begin
            s.level = LVL_CORE; s.colour = COLOUR_CORE;
        end else if (s.field_sum > glow_mirror) begin
            s.level = LVL_GLOW; s.colour = COLOUR_GLOW;
        end else begin
            s.level = LVL_BACK; s.colour = COLOUR_BACK;
        end
        return s;
    endfunction

    assign o_pending = shade_queue.size();

    always @(posedge i_clk) begin
        t_shade want, got;
        if (!i_rst_n) begin
            for (int b = 0; b < MAX_BLOBS; b++) blob_mirror[b] <= BLOB_RESET[b];
            core_mirror <= CORE_TH_RESET;
            glow_mirror <= GLOW_TH_RESET;
            shade_queue.delete();
            o_fail_count <= 0;
            o_pixel_count <= 0;
        end else begin
            // register writes
            if (i_cfg_we) begin
                if (i_cfg_idx < MAX_BLOBS) blob_mirror[i_cfg_idx] <= i_cfg_data;
                else if (i_cfg_idx == REG_CORE) core_mirror <= i_cfg_data[SUM_W-1:0];
                else if (i_cfg_idx == REG_GLOW) glow_mirror <= i_cfg_data[SUM_W-1:0];
            end
            // input transaction
            if (i_in_valid && i_in_ready) begin
                shade_queue.push_back(shade_pixel(i_in_data[5:0], i_in_data[10:6]));
                o_pixel_count <= o_pixel_count + 1;
            end
            // result transaction
            if (i_out_valid && i_out_ready) begin
                got.level     = t_level'(i_out_data[1:0]);
                got.colour    = i_out_data[17:2];
                got.field_sum = i_out_data[34:18];
                if (shade_queue.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("ERROR: unexpected result %h", i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = shade_queue.pop_front();
                    if (want !== got || i_out_data[39:35] !== 5'd0) begin
                        if (o_fail_count < 10)
                            $display("ERROR: exp lvl %0d col %h sum %0d, got lvl %0d col %h sum %0d",
                                     want.level, want.colour, want.field_sum,
                                     got.level, got.colour, got.field_sum);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

/* sim/metaball_field_threshold_test.sv */
// Top of the metaball field testbench: clock, reset, register phases, pixel stimulus, verdict.
`timescale 1ns / 1ps
`default_nettype none
module metaball_field_threshold_test;
    import mbft_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PIXELS = 400;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [15:0]       s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [39:0]       m_axis_tdata;
    logic              i_cfg_we = 1'b0;
    logic [IDX_W-1:0]  i_cfg_idx = '0;
    logic [BLOB_W-1:0] i_cfg_data = '0;
    int                fail_count, pending, pixel_count;
    int                cycle_count = 0;
    int                hold_off = 0;
    bit                calm_send = 0, calm_take = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    metaball_field_threshold DUT (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data
    );

    metaball_field_threshold_checker checker_inst (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready), .i_out_data(m_axis_tdata),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending), .o_pixel_count(pixel_count)
    );

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("metaball_field_threshold verification failed");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            m_axis_tready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            m_axis_tready <= calm_take || ($urandom_range(99) >= 38);
        end
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [BLOB_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // One pixel transaction with random idle gaps before it; valid stays up for a follower
    task automatic send_pixel(logic [PX_W-1:0] px, logic [PY_W-1:0] py);
        while (!calm_send && $urandom_range(99) < 38) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, py, px};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    function automatic logic [BLOB_W-1:0] blob_word(int cx, int cy, int w);
        return {w[7:0], cy[8:0], cx[9:0]};
    endfunction

    task automatic random_pixels(int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(3) == 0)
                send_pixel(PX_W'($urandom), PY_W'($urandom));
            else
                send_pixel(PX_W'($urandom_range(63)), PY_W'($urandom_range(31)));
        end
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset registers, corners and blob centers
        send_pixel(0, 0);  send_pixel(63, 31); send_pixel(63, 0); send_pixel(0, 31);
        send_pixel(6'h2A, 5'h15); send_pixel(6'h15, 5'h0A);
        for (int k = 0; k < 5; k++)
            send_pixel(BLOB_RESET[k][9:4], BLOB_RESET[k][18:14]);
        drain();

        // Saturation: five full-weight blobs stacked on one spot
        for (int b = 0; b < MAX_BLOBS; b++) write_reg(IDX_W'(b), blob_word(320, 256, 255));
        write_reg(REG_CORE, BLOB_W'(17'h1FFFF));
        write_reg(REG_GLOW, BLOB_W'(17'h1FFFE));
        send_pixel(20, 16); send_pixel(21, 16); send_pixel(0, 0);
        drain();

        // Thresholds inverted, extreme centers, out-of-range index, high bits
        write_reg(0, 27'h7FFFFFF);
        write_reg(1, 27'd0);
        write_reg(2, blob_word(1023, 0, 1));
        write_reg(REG_CORE, BLOB_W'(17'd100));
        write_reg(REG_GLOW, BLOB_W'(17'd5000));
        write_reg(3'd7, 27'h5555555);
        send_pixel(63, 31); send_pixel(0, 0); send_pixel(63, 0); send_pixel(20, 16);
        send_pixel(0, 31);
        drain();
        write_reg(REG_CORE, BLOB_W'(17'd0));
        write_reg(REG_GLOW, BLOB_W'(17'd0));
        send_pixel(0, 0); send_pixel(40, 10);
        drain();

        // Random phases with random blobs; first phase starts with a long stall
        for (int phase = 0; phase < 4; phase++) begin
            for (int b = 0; b < MAX_BLOBS; b++) write_reg(IDX_W'(b), BLOB_W'($urandom));
            write_reg(REG_CORE, BLOB_W'($urandom_range(4000, 200)));
            write_reg(REG_GLOW, BLOB_W'($urandom_range(2000, 0)));
            if (phase == 0) hold_off = 200;
            calm_send = (phase == 2);
            calm_take = (phase == 2);
            random_pixels(RANDOM_PIXELS / 4);
            drain();
        end

        $display("covered %0d pixels over saturation, inverted thresholds and random blob sets",
                 pixel_count);
        if (fail_count == 0)
            $display("metaball_field_threshold verification clean");
        else
            $display("metaball_field_threshold verification failed");
        $finish;
    end
endmodule
`default_nettype wire
